/* hdl/tvss_pkg.sv */
// tvss_pkg: shared types and constants for the text video scanline sequencer
// used by every module of the block; no dependencies

package tvss_pkg;

    localparam int LINE_W  = 9;
    localparam int PTR_W   = 12;
    localparam int VLINE_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_EVEN_FIELD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VSYNC_LINE = 2'd1;

    localparam logic [VLINE_W-1:0] VSYNC_LINE_RESET = 8'd230;
    localparam logic [5:0] SIXTY = 6'd60;

    typedef enum logic [1:0] {
        PULSE_NONE  = 2'd0,
        PULSE_HSYNC = 2'd1,
        PULSE_EQU   = 2'd2,
        PULSE_BROAD = 2'd3
    } pulse_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              active;
        logic [PTR_W-1:0]  base;
        logic [2:0]        font_row;
        pulse_t            p1;
        pulse_t            p2;
        logic              vsync;
    } line_info_t;

    typedef struct packed {
        logic [5:0]  fields;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [7:0]  hours;
        logic [31:0] ticks;
    } time_t;

    typedef struct packed {
        line_info_t info;
        time_t      clock;
    } result_t;

endpackage

/* hdl/tvss_line_seq.sv */
// tvss_line_seq: line counter, row pointer, blank flag, vsync level and sync pulse decode
// depends on tvss_pkg

module tvss_line_seq #(
    parameter int TEXT_COLUMNS = 40,
    parameter int TEXT_ROWS    = 26,
    parameter int LAST_LINE    = 262
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          blank_now,
    input  logic                          even_field,
    input  logic [tvss_pkg::VLINE_W-1:0]  vsync_line,
    output tvss_pkg::line_info_t          info,
    output logic                          advance
);

    localparam logic [tvss_pkg::LINE_W:0] ACTIVE_LINES = (tvss_pkg::LINE_W+1)'(TEXT_ROWS * 8);
    localparam logic [tvss_pkg::LINE_W:0] LAST = (tvss_pkg::LINE_W+1)'(LAST_LINE);
    localparam logic [tvss_pkg::PTR_W-1:0] COLS = tvss_pkg::PTR_W'(TEXT_COLUMNS);

    logic [tvss_pkg::LINE_W-1:0] line_reg, line_next;
    logic [tvss_pkg::PTR_W-1:0]  ptr_reg, ptr_next, ptr_dec;
    logic                        blank_reg, blank_next, blank_eff;
    logic                        vsync_reg, vsync_next;
    logic [tvss_pkg::LINE_W:0]   line_x, vl_x, diff, line_inc;
    tvss_pkg::pulse_t            p1, p2;
    logic                        active;
    logic [tvss_pkg::PTR_W-1:0]  base;
    logic                        adv;

    always_comb
    begin
        line_x    = {1'b0, line_reg};
        vl_x      = (tvss_pkg::LINE_W+1)'(vsync_line);
        diff      = line_x - vl_x;
        blank_eff = blank_reg | blank_now;
        ptr_dec   = (line_reg[2:0] != 3'd0) ? ptr_reg - COLS : ptr_reg;
        ptr_next  = ptr_reg;
        blank_next = blank_eff;
        vsync_next = vsync_reg;
        p1        = tvss_pkg::PULSE_HSYNC;
        p2        = tvss_pkg::PULSE_NONE;
        active    = 1'b0;
        base      = '0;
        adv       = 1'b0;
        if (line_x < ACTIVE_LINES)
        begin
            if (!blank_eff)
            begin
                active   = 1'b1;
                base     = ptr_dec;
                ptr_next = ptr_dec + COLS;
            end
            else if (line_reg[2:0] == 3'd0)
            begin
                ptr_next = ptr_reg + COLS;
            end
        end
        else if (line_x == ACTIVE_LINES)
        begin
            ptr_next = '0;
            p1       = tvss_pkg::PULSE_NONE;
        end
        else if (line_x + 10'd5 == vl_x)
        begin
            vsync_next = 1'b1;
        end
        else if (line_x >= vl_x && diff <= 10'd8)
        begin
            unique case (diff[3:0])
                4'd0, 4'd1, 4'd6:
                begin
                    p1 = tvss_pkg::PULSE_EQU;
                    p2 = tvss_pkg::PULSE_EQU;
                end
                4'd2:
                begin
                    p1 = tvss_pkg::PULSE_EQU;
                    p2 = even_field ? tvss_pkg::PULSE_EQU : tvss_pkg::PULSE_BROAD;
                end
                4'd3, 4'd4:
                begin
                    p1 = tvss_pkg::PULSE_BROAD;
                    p2 = tvss_pkg::PULSE_BROAD;
                end
                4'd5:
                begin
                    p1 = even_field ? tvss_pkg::PULSE_BROAD : tvss_pkg::PULSE_NONE;
                    p2 = even_field ? tvss_pkg::PULSE_BROAD : tvss_pkg::PULSE_NONE;
                end
                4'd7:
                begin
                    p1 = even_field ? tvss_pkg::PULSE_EQU : tvss_pkg::PULSE_NONE;
                    p2 = even_field ? tvss_pkg::PULSE_EQU : tvss_pkg::PULSE_NONE;
                end
                default:
                begin
                    // end of the sync group: field done
                    vsync_next = 1'b0;
                    blank_next = 1'b0;
                    adv        = 1'b1;
                end
            endcase
        end
        line_inc  = line_x + 10'd1;
        line_next = (line_inc > LAST) ? '0 : line_inc[tvss_pkg::LINE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            ptr_reg   <= '0;
            blank_reg <= 1'b0;
            vsync_reg <= 1'b0;
        end
        else if (accept)
        begin
            line_reg  <= line_next;
            ptr_reg   <= ptr_next;
            blank_reg <= blank_next;
            vsync_reg <= vsync_next;
        end
    end

    assign info.line     = line_reg;
    assign info.active   = active;
    assign info.base     = base;
    assign info.font_row = line_reg[2:0];
    assign info.p1       = p1;
    assign info.p2       = p2;
    assign info.vsync    = vsync_next;
    assign advance       = adv;

endmodule

/* hdl/tvss_time_clock.sv */
// tvss_time_clock: field / second / minute / hour clock and total field count
// depends on tvss_pkg

module tvss_time_clock (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            advance,
    output tvss_pkg::time_t clock_next
);

    tvss_pkg::time_t t_reg, t_next;
    logic [5:0] f_inc, s_inc, m_inc;

    always_comb
    begin
        t_next = t_reg;
        f_inc  = t_reg.fields + 6'd1;
        s_inc  = t_reg.seconds + 6'd1;
        m_inc  = t_reg.minutes + 6'd1;
        if (advance)
        begin
            t_next.ticks  = t_reg.ticks + 32'd1;
            t_next.fields = f_inc;
            if (f_inc == tvss_pkg::SIXTY)
            begin
                t_next.fields  = '0;
                t_next.seconds = s_inc;
                if (s_inc == tvss_pkg::SIXTY)
                begin
                    t_next.seconds = '0;
                    t_next.minutes = m_inc;
                    if (m_inc == tvss_pkg::SIXTY)
                    begin
                        t_next.minutes = '0;
                        t_next.hours   = t_reg.hours + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_reg <= '0;
        else if (accept)
            t_reg <= t_next;
    end

    assign clock_next = t_next;

endmodule

/* hdl/text_video_scanline_sequencer_top.sv */
// text_video_scanline_sequencer_top: scanline sequencer top level with config registers
// and a two-entry output buffer; depends on tvss_pkg, tvss_line_seq, tvss_time_clock

// One item is one horizontal line tick. The line, pointer and clock state update
// at the accept edge, which also registers the item's result for the output.
// A new item is taken every cycle while in_stall is low; the output register
// plus a one-entry skid stage let one more item in while a result is held by
// out_stall, after which in_stall rises until the skid drains.
// Configuration (even_field, vsync_line) is always ready and should be written
// only while no item is in flight.

module text_video_scanline_sequencer_top #(
    parameter int TEXT_COLUMNS = 40,
    parameter int TEXT_ROWS    = 26,
    parameter int LAST_LINE    = 262
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tvss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tvss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              blank_now,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [8:0]                        line_number,
    output logic                              active_video,
    output logic [11:0]                       row_base,
    output logic [2:0]                        font_row,
    output logic [1:0]                        first_pulse,
    output logic [1:0]                        second_pulse,
    output logic                              vsync_level,
    output logic [5:0]                        field_count,
    output logic [5:0]                        seconds_count,
    output logic [5:0]                        minutes_count,
    output logic [7:0]                        hours_count,
    output logic [31:0]                       tick_count
);

    logic                           even_field_reg;
    logic [tvss_pkg::VLINE_W-1:0]   vsync_line_reg;
    logic                           accept, advance, out_take;
    tvss_pkg::line_info_t           info;
    tvss_pkg::time_t                clock_next;
    tvss_pkg::result_t              new_res;
    tvss_pkg::result_t              out_reg, skid_reg;
    logic                           out_valid_reg, skid_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_field_reg <= 1'b0;
            vsync_line_reg <= tvss_pkg::VSYNC_LINE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tvss_pkg::REG_EVEN_FIELD)
                even_field_reg <= cfg_data[0];
            else if (cfg_index == tvss_pkg::REG_VSYNC_LINE)
                vsync_line_reg <= cfg_data;
        end
    end

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    tvss_line_seq #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS),
        .LAST_LINE    (LAST_LINE)
    ) u_line_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .blank_now  (blank_now),
        .even_field (even_field_reg),
        .vsync_line (vsync_line_reg),
        .info       (info),
        .advance    (advance)
    );

    tvss_time_clock u_time_clock (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .advance    (advance),
        .clock_next (clock_next)
    );

    assign new_res.info  = info;
    assign new_res.clock = clock_next;

    // control of the output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= new_res;
        end
        else if (accept)
        begin
            skid_reg <= new_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_number   = out_reg.info.line;
    assign active_video  = out_reg.info.active;
    assign row_base      = out_reg.info.base;
    assign font_row      = out_reg.info.font_row;
    assign first_pulse   = out_reg.info.p1;
    assign second_pulse  = out_reg.info.p2;
    assign vsync_level   = out_reg.info.vsync;
    assign field_count   = out_reg.clock.fields;
    assign seconds_count = out_reg.clock.seconds;
    assign minutes_count = out_reg.clock.minutes;
    assign hours_count   = out_reg.clock.hours;
    assign tick_count    = out_reg.clock.ticks;

endmodule

/* hdl/tvss_checker.sv */
// tvss_checker: port-level checks on the scanline sequencer top level, bound to it
// depends on tvss_pkg and text_video_scanline_sequencer_top

module tvss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [8:0]  line_number,
    input logic        active_video,
    input logic [11:0] row_base,
    input logic [2:0]  font_row,
    input logic [1:0]  first_pulse,
    input logic [1:0]  second_pulse
);

    // a held item stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_number) && $stable(row_base))
        else $error("held item changed");

    a_font_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> font_row == line_number[2:0])
        else $error("font row does not follow line number");

    a_blank_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active_video |-> row_base == 12'd0)
        else $error("row base set on a line without pixels");

    // drawn lines only carry a plain hsync
    a_active_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_video |->
            first_pulse == tvss_pkg::PULSE_HSYNC && second_pulse == tvss_pkg::PULSE_NONE)
        else $error("sync pulse on a drawn line");

endmodule

bind text_video_scanline_sequencer_top tvss_checker u_tvss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_number  (line_number),
    .active_video (active_video),
    .row_base     (row_base),
    .font_row     (font_row),
    .first_pulse  (first_pulse),
    .second_pulse (second_pulse)
);
